>>> src/lsbwm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the lsb watermark embed/extract block
// no dependencies

package lsbwm_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;
   localparam int MARK_DEPTH_DEF = 512;

   localparam int BYTE_W   = 8;
   localparam int WIDTH_W  = 13;
   localparam int HEIGHT_W = 13;
   localparam int LEN_W    = 10;
   localparam int IDX_W    = 9;
   localparam int CBYTE_W  = 15;   // colour bytes per row, width * 3
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_IMAGE = 2'd1,
      CMD_START = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      REG_MODE   = 2'd0,
      REG_WIDTH  = 2'd1,
      REG_HEIGHT = 2'd2,
      REG_LENGTH = 2'd3
   } reg_type;

   localparam logic MODE_EMBED   = 1'b0;
   localparam logic MODE_EXTRACT = 1'b1;

   // live configuration as seen by the datapath
   typedef struct packed {
      logic                mode;
      logic [CBYTE_W-1:0]  colour_bytes;
      logic [CBYTE_W-1:0]  row_bytes;
      logic [HEIGHT_W-1:0] height;
      logic [LEN_W-1:0]    mark_length;
      logic [LEN_W-1:0]    capacity;
   } cfg_type;

endpackage

>>> src/lsbwm_csr.sv
`timescale 1ns / 1ps
// configuration registers with apb-style access, plus derived row geometry
// and a registered, saturated capacity; depends on lsbwm_pkg

module lsbwm_csr #(
   parameter int MAX_WIDTH  = lsbwm_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lsbwm_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lsbwm_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [lsbwm_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [lsbwm_pkg::DATA_W-1:0]  csr_prdata,
   output logic                          csr_pready,
   output lsbwm_pkg::cfg_type            cfg
);
   import lsbwm_pkg::*;

   logic                  mode_ff,   mode_in;
   logic [WIDTH_W-1:0]    width_ff,  width_in;
   logic [HEIGHT_W-1:0]   height_ff, height_in;
   logic [LEN_W-1:0]      length_ff, length_in;
   logic [CBYTE_W-1:0]    colour_ff, colour_in;
   logic [CBYTE_W-1:0]    rowb_ff,   rowb_in;
   logic [HEIGHT_W-1:0]   hcl_ff,    hcl_in;
   logic [LEN_W-1:0]      cap_ff,    cap_in;

   logic                  wr;
   logic [1:0]            reg_idx;
   logic [WIDTH_W-1:0]    w_raw, w_cl;
   logic [HEIGHT_W-1:0]   h_raw;
   logic [CBYTE_W-1:0]    colour_new;
   logic [CBYTE_W+HEIGHT_W-1:0] prod;

   assign wr      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx = csr_paddr[3:2];
   assign w_raw   = csr_pwdata[WIDTH_W-1:0];
   assign h_raw   = csr_pwdata[HEIGHT_W-1:0];

   always_comb begin
      if (w_raw == '0) begin
         w_cl = WIDTH_W'(1);
      end else if (32'(w_raw) > MAX_WIDTH) begin
         w_cl = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_cl = w_raw;
      end
      colour_new = {2'b00, w_cl} + {1'b0, w_cl, 1'b0};
   end

   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      length_in = length_ff;
      colour_in = colour_ff;
      rowb_in   = rowb_ff;
      hcl_in    = hcl_ff;
      if (wr) begin
         case (reg_idx)
            REG_MODE: begin
               mode_in = csr_pwdata[0];
            end
            REG_WIDTH: begin
               width_in  = w_raw;
               colour_in = colour_new;
               // row length rounded up to a multiple of four bytes
               rowb_in   = (colour_new + CBYTE_W'(3)) & ~CBYTE_W'(3);
            end
            REG_HEIGHT: begin
               height_in = h_raw;
               if (h_raw == '0) begin
                  hcl_in = HEIGHT_W'(1);
               end else if (32'(h_raw) > MAX_HEIGHT) begin
                  hcl_in = HEIGHT_W'(MAX_HEIGHT);
               end else begin
                  hcl_in = h_raw;
               end
            end
            REG_LENGTH: begin
               length_in = csr_pwdata[LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // capacity in bytes = colour bytes * rows / 8, saturated to the length range
   assign prod   = {{HEIGHT_W{1'b0}}, colour_ff} * {{CBYTE_W{1'b0}}, hcl_ff};
   assign cap_in = (|prod[CBYTE_W+HEIGHT_W-1:LEN_W+3]) ? '1 : prod[LEN_W+2:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_EMBED;
         width_ff  <= WIDTH_W'(1);
         height_ff <= HEIGHT_W'(1);
         length_ff <= '0;
         colour_ff <= CBYTE_W'(3);
         rowb_ff   <= CBYTE_W'(4);
         hcl_ff    <= HEIGHT_W'(1);
         cap_ff    <= '0;
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         length_ff <= length_in;
         colour_ff <= colour_in;
         rowb_ff   <= rowb_in;
         hcl_ff    <= hcl_in;
         cap_ff    <= cap_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MODE:   csr_prdata = DATA_W'(mode_ff);
         REG_WIDTH:  csr_prdata = DATA_W'(width_ff);
         REG_HEIGHT: csr_prdata = DATA_W'(height_ff);
         REG_LENGTH: csr_prdata = DATA_W'(length_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   assign cfg.mode         = mode_ff;
   assign cfg.colour_bytes = colour_ff;
   assign cfg.row_bytes    = rowb_ff;
   assign cfg.height       = hcl_ff;
   assign cfg.mark_length  = length_ff;
   assign cfg.capacity     = cap_ff;

endmodule

>>> src/lsbwm_mark_ram.sv
`timescale 1ns / 1ps
// mark byte store: one write port, one read port, registered read data
// depends on lsbwm_pkg

module lsbwm_mark_ram #(
   parameter int DEPTH = lsbwm_pkg::MARK_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [lsbwm_pkg::BYTE_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [lsbwm_pkg::BYTE_W-1:0]  rd_data
);
   import lsbwm_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/lsbwm_core.sv
`timescale 1ns / 1ps
// frame counters, command decode, mark store access and the two-stage
// result pipeline; depends on lsbwm_pkg

module lsbwm_core #(
   parameter int MARK_DEPTH = lsbwm_pkg::MARK_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lsbwm_pkg::cfg_type                cfg,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lsbwm_pkg::DATA_W-1:0]      req_tdata,
   input  logic [lsbwm_pkg::CMD_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lsbwm_pkg::DATA_W-1:0]      rsp_tdata,
   output logic [1:0]                        rsp_tuser,
   output logic                              mem_wr_en,
   output logic [$clog2(MARK_DEPTH)-1:0]     mem_wr_addr,
   output logic [lsbwm_pkg::BYTE_W-1:0]      mem_wr_data,
   output logic                              mem_rd_en,
   output logic [$clog2(MARK_DEPTH)-1:0]     mem_rd_addr,
   input  logic [lsbwm_pkg::BYTE_W-1:0]      mem_rd_data
);
   import lsbwm_pkg::*;

   localparam int AW = $clog2(MARK_DEPTH);

   typedef struct packed {
      logic [BYTE_W-1:0] image_byte;
      logic              embed;
      logic [2:0]        bit_sel;
      logic              is_padding;
      logic              xvalid;
      logic [BYTE_W-1:0] xbyte;
      logic [IDX_W-1:0]  xindex;
      logic              finished;
      logic              is_start;
   } p1_type;

   typedef struct packed {
      logic [BYTE_W-1:0] image_out;
      logic              is_padding;
      logic              xvalid;
      logic [BYTE_W-1:0] xbyte;
      logic [IDX_W-1:0]  xindex;
      logic              finished;
   } out_type;

   logic [HEIGHT_W-1:0] row_cnt_ff,  row_cnt_in;
   logic [CBYTE_W-1:0]  row_byte_ff, row_byte_in;
   logic [2:0]          bit_pos_ff,  bit_pos_in;
   logic [LEN_W-1:0]    byte_pos_ff, byte_pos_in;
   logic [BYTE_W-1:0]   gather_ff,   gather_in;
   logic [LEN_W-1:0]    eff_ff,      eff_in;
   logic                pend_ff,     pend_in;
   logic                p1_v_ff,     p1_v_in;
   p1_type              p1_ff,       p1_in;
   logic                out_v_ff,    out_v_in;
   out_type             out_ff,      out_in;

   logic                in_acc, p1_move;
   logic [IDX_W-1:0]    mark_index;
   logic [BYTE_W-1:0]   mark_data, image_byte;
   logic [LEN_W-1:0]    len_cl, eff_new, eff_now;
   logic                padding, frame_done, active, row_end;
   logic [BYTE_W-1:0]   gather_next;
   logic [CBYTE_W-1:0]  row_byte_next;

   assign mark_index = req_tdata[IDX_W-1:0];
   assign mark_data  = req_tdata[IDX_W+BYTE_W-1:IDX_W];
   assign image_byte = req_tdata[IDX_W+2*BYTE_W-1:IDX_W+BYTE_W];

   assign p1_move    = p1_v_ff & (~out_v_ff | rsp_tready);
   assign req_tready = ~p1_v_ff | p1_move;
   assign in_acc     = req_tvalid & req_tready;

   // a start latches the length in the cycle after it, once capacity has settled
   always_comb begin
      if (32'(cfg.mark_length) > MARK_DEPTH) begin
         len_cl = LEN_W'(MARK_DEPTH);
      end else begin
         len_cl = cfg.mark_length;
      end
      eff_new = (len_cl > cfg.capacity) ? cfg.capacity : len_cl;
      eff_now = pend_ff ? eff_new : eff_ff;
   end

   assign padding       = row_byte_ff >= cfg.colour_bytes;
   assign frame_done    = row_cnt_ff >= cfg.height;
   assign active        = ~padding & ~frame_done & (byte_pos_ff < eff_now);
   assign gather_next   = gather_ff | (BYTE_W'(image_byte[0]) << (3'd7 - bit_pos_ff));
   assign row_byte_next = row_byte_ff + CBYTE_W'(1);
   assign row_end       = row_byte_next >= cfg.row_bytes;

   assign mem_wr_addr = AW'(mark_index);
   assign mem_wr_data = mark_data;
   assign mem_rd_addr = AW'(byte_pos_ff);

   always_comb begin
      row_cnt_in  = row_cnt_ff;
      row_byte_in = row_byte_ff;
      bit_pos_in  = bit_pos_ff;
      byte_pos_in = byte_pos_ff;
      gather_in   = gather_ff;
      eff_in      = eff_ff;
      pend_in     = pend_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      p1_in       = '0;
      if (pend_ff) begin
         eff_in  = eff_new;
         pend_in = 1'b0;
      end
      if (in_acc) begin
         case (req_tuser)
            CMD_LOAD: begin
               mem_wr_en = 32'(mark_index) < MARK_DEPTH;
            end
            CMD_IMAGE: begin
               p1_in.image_byte = image_byte;
               p1_in.is_padding = padding;
               if (active) begin
                  bit_pos_in = bit_pos_ff + 3'd1;
                  if (cfg.mode == MODE_EMBED) begin
                     mem_rd_en     = 1'b1;
                     p1_in.embed   = 1'b1;
                     p1_in.bit_sel = 3'd7 - bit_pos_ff;
                  end else begin
                     gather_in = gather_next;
                  end
                  if (bit_pos_ff == 3'd7) begin
                     if (cfg.mode == MODE_EXTRACT) begin
                        p1_in.xvalid = 1'b1;
                        p1_in.xbyte  = gather_next;
                        p1_in.xindex = byte_pos_ff[IDX_W-1:0];
                     end
                     gather_in   = '0;
                     byte_pos_in = byte_pos_ff + LEN_W'(1);
                  end
               end
               if (row_end) begin
                  row_byte_in = '0;
                  if (!frame_done) begin
                     row_cnt_in = row_cnt_ff + HEIGHT_W'(1);
                  end
               end else begin
                  row_byte_in = row_byte_next;
               end
            end
            CMD_START: begin
               row_cnt_in     = '0;
               row_byte_in    = '0;
               bit_pos_in     = '0;
               byte_pos_in    = '0;
               gather_in      = '0;
               pend_in        = 1'b1;
               p1_in.is_start = 1'b1;
            end
            default: begin
            end
         endcase
      end
      p1_in.finished = byte_pos_in >= eff_now;
   end

   always_comb begin
      p1_v_in = p1_v_ff;
      if (in_acc) begin
         p1_v_in = 1'b1;
      end else if (p1_move) begin
         p1_v_in = 1'b0;
      end

      out_v_in = out_v_ff;
      if (p1_move) begin
         out_v_in = 1'b1;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end

      out_in.image_out  = p1_ff.embed ? {p1_ff.image_byte[BYTE_W-1:1], mem_rd_data[p1_ff.bit_sel]}
                                      : p1_ff.image_byte;
      out_in.is_padding = p1_ff.is_padding;
      out_in.xvalid     = p1_ff.xvalid;
      out_in.xbyte      = p1_ff.xbyte;
      out_in.xindex     = p1_ff.xindex;
      // after a start the position is zero, so done means an empty mark
      out_in.finished   = p1_ff.is_start ? (eff_now == '0) : p1_ff.finished;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff  <= '0;
         row_byte_ff <= '0;
         bit_pos_ff  <= '0;
         byte_pos_ff <= '0;
         gather_ff   <= '0;
         eff_ff      <= '0;
         pend_ff     <= 1'b0;
         p1_v_ff     <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         row_cnt_ff  <= row_cnt_in;
         row_byte_ff <= row_byte_in;
         bit_pos_ff  <= bit_pos_in;
         byte_pos_ff <= byte_pos_in;
         gather_ff   <= gather_in;
         eff_ff      <= eff_in;
         pend_ff     <= pend_in;
         p1_v_ff     <= p1_v_in;
         out_v_ff    <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc) begin
         p1_ff <= p1_in;
      end
      if (p1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {6'b000000, out_ff.finished, out_ff.xindex, out_ff.xbyte,
                        out_ff.image_out};
   assign rsp_tuser  = {out_ff.xvalid, out_ff.is_padding};

endmodule

>>> src/lsb_watermark_embed_extract_top.sv
`timescale 1ns / 1ps
// channel    dir  handshake                      contents
// req_       in   req_tvalid/req_tready          command, mark load, raster byte
// rsp_       out  rsp_tvalid/rsp_tready          one result per accepted command
// csr_       in   psel/penable/pwrite, pready=1  mode, width, height, mark length
//
// one beat per clock in and out while rsp_tready is high; a result passes the p1
// register, which takes the mark store read alongside, then the output register
// reset is synchronous; counters and flags clear at once, the mark store is not
// cleared and must be loaded before use
// a stalled result holds one more beat in the pipe, then req_tready drops

module lsb_watermark_embed_extract_top #(
   parameter int MAX_WIDTH  = lsbwm_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lsbwm_pkg::MAX_HEIGHT_DEF,
   parameter int MARK_DEPTH = lsbwm_pkg::MARK_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // mark_index[8:0], mark_data[16:9], image_byte[24:17], zero fill above
   input  logic [lsbwm_pkg::DATA_W-1:0]  req_tdata,
   // command[1:0]
   input  logic [lsbwm_pkg::CMD_W-1:0]   req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // image_out[7:0], extract_byte[15:8], extract_index[24:16], finished[25]
   output logic [lsbwm_pkg::DATA_W-1:0]  rsp_tdata,
   // is_padding[0], extract_valid[1]
   output logic [1:0]                    rsp_tuser,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lsbwm_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [lsbwm_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [lsbwm_pkg::DATA_W-1:0]  csr_prdata,
   output logic                          csr_pready
);
   import lsbwm_pkg::*;

   localparam int AW = $clog2(MARK_DEPTH);

   cfg_type           cfg;
   logic              mem_wr_en, mem_rd_en;
   logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
   logic [BYTE_W-1:0] mem_wr_data, mem_rd_data;

   lsbwm_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lsbwm_mark_ram #(
      .DEPTH (MARK_DEPTH)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lsbwm_core #(
      .MARK_DEPTH (MARK_DEPTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

endmodule

>>> src/lsbwm_checker.sv
`timescale 1ns / 1ps
// port-level checks for the watermark block, bound to the top level
// depends on lsbwm_pkg and lsb_watermark_embed_extract_top

module lsbwm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [lsbwm_pkg::DATA_W-1:0]  rsp_tdata,
   input logic [1:0]                    rsp_tuser
);
   import lsbwm_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // an extracted byte only completes on a colour byte
   a_xvalid_not_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("extracted byte flagged on padding");

   // input backpressure only comes from a stalled output
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind lsb_watermark_embed_extract_top lsbwm_checker u_checker (.*);
